### design/c2d_pkg.sv
// Shared types, constants and helpers for the streaming 3x3 convolution block.
package c2d_pkg;

   // Geometry
   localparam int MAX_WIDTH      = 1024;
   localparam int MIN_DIM        = 3;
   localparam int KTAPS          = 3;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS    = 16;
   localparam int ROW_BITS       = HEIGHT_BITS + 1;
   localparam int CFG_WIDTH_BITS = 11;

   // Arithmetic
   localparam int PIXEL_BITS   = 16;
   localparam int COEF_BITS    = 16;
   localparam int COEF_FRAC    = 12;
   localparam int PROD_BITS    = PIXEL_BITS + COEF_BITS;
   localparam int ROWSUM_BITS  = PROD_BITS + 2;
   localparam int ACC_BITS     = PROD_BITS + 4;
   localparam int Q_BITS       = ACC_BITS - COEF_FRAC;
   localparam int LINE_BITS    = 2 * PIXEL_BITS;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int KROW_BITS      = KTAPS * COEF_BITS;
   localparam int CSR_DATA_BITS  = KROW_BITS;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QLEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [ROWSUM_BITS-1:0] rowsum_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [Q_BITS-1:0]     quot_type;

   typedef pixel_type [KTAPS-1:0][KTAPS-1:0] window_type;
   typedef coef_type  [KTAPS-1:0]            kernel_row_type;
   typedef kernel_row_type [KTAPS-1:0]       kernel_type;

   localparam acc_type  ROUND_BIAS = ACC_BITS'(1 << (COEF_FRAC - 1));
   localparam quot_type SAT_HI     = Q_BITS'((1 << (PIXEL_BITS - 1)) - 1);
   localparam quot_type SAT_LO     = -SAT_HI - Q_BITS'(1);

   localparam coef_type COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_KERNEL_TOP    = 3'd2,
      REG_KERNEL_MIDDLE = 3'd3,
      REG_KERNEL_BOTTOM = 3'd4
   } reg_index_type;

   // Frame size in use
   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
   } dims_type;

   // One convolution job: masked taps plus end-of-frame flag
   typedef struct packed {
      window_type taps;
      logic       last;
   } job_type;

   typedef struct packed {
      logic                   not_empty;
      logic [QLEVEL_BITS-1:0] level;
   } queue_status_type;

   // Clamp a written width to [MIN_DIM, MAX_WIDTH]
   function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [CFG_WIDTH_BITS-1:0] value);
      logic [WIDTH_BITS-1:0] result;
      if (int'(value) < MIN_DIM) begin
         result = WIDTH_BITS'(MIN_DIM);
      end else if (int'(value) > MAX_WIDTH) begin
         result = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         result = WIDTH_BITS'(value);
      end
      return result;
   endfunction

   // Raise a written height to at least MIN_DIM
   function automatic logic [HEIGHT_BITS-1:0] clamp_height(input logic [HEIGHT_BITS-1:0] value);
      logic [HEIGHT_BITS-1:0] result;
      if (int'(value) < MIN_DIM) begin
         result = HEIGHT_BITS'(MIN_DIM);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

### design/c2d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### design/c2d_queue.sv
// Short job queue between the window front end and the arithmetic back end.
module c2d_queue import c2d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLEVEL_BITS-1:0] level_ff, level_in;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = (level_ff != '0);
   assign status.level     = level_ff;

   // The front end's credit check must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff < QLEVEL_BITS'(QUEUE_DEPTH)))
      else $error("queue push while full");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("queue pop while empty");

endmodule

### design/c2d_front.sv
// Front end: raster counters, line store, 3x3 window and masked job build.
module c2d_front import c2d_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  dims_type               dims,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pixel_type              req_pixel,
   input  logic                   req_drain,
   input  logic [QLEVEL_BITS-1:0] queue_level,
   output logic                   job_push,
   output job_type                job
);

   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [COL_BITS-1:0]  col_ff, col_in;

   logic                 b_valid_ff;
   logic                 b_emit_ff;
   logic                 b_special_ff;
   logic                 b_last_ff;
   logic [COL_BITS-1:0]  b_col_ff;
   pixel_type            b_pixel_ff;
   logic [KTAPS-1:0]     b_rmask_ff;
   logic [KTAPS-1:0]     b_cmask_ff;
   window_type           win_ff, win_in;

   logic                 accept;
   logic                 pending;
   logic [ROW_BITS-1:0]  h_ext, h1;
   logic                 bad_pos;
   logic [ROW_BITS-1:0]  row_e, row_b;
   logic [COL_BITS-1:0]  col_e;
   logic [WIDTH_BITS-1:0] col_inc;
   logic                 special, normal, last;
   pixel_type            pix;
   logic [KTAPS-1:0]     rmask, cmask;
   logic [LINE_BITS-1:0] line_rd;
   pixel_type            line_old, line_older;
   pixel_type [KTAPS-1:0] new_col;

   // Hold back input unless the queue has a slot for this word and the one in flight
   assign pending    = b_valid_ff && b_emit_ff;
   assign req_tready = (queue_level + QLEVEL_BITS'(pending)) < QLEVEL_BITS'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   // Classify the incoming word by its position in the extended frame
   always_comb begin
      h_ext   = ROW_BITS'(dims.height);
      h1      = h_ext + 1'b1;
      bad_pos = (WIDTH_BITS'(col_ff) >= dims.width) || (row_ff > h1) ||
                ((row_ff == h1) && (col_ff != '0));
      row_e   = bad_pos ? '0 : row_ff;
      col_e   = bad_pos ? '0 : col_ff;
      pix     = ((row_e < h_ext) && !req_drain) ? req_pixel : '0;
      special = (col_e == '0) && (row_e >= ROW_BITS'(2));
      normal  = (col_e != '0) && (row_e != '0);
      last    = special && (row_e == h1);
      // bottom window row; the two above it follow
      row_b    = special ? row_e - 1'b1 : row_e;
      rmask[2] = row_b < h_ext;
      rmask[1] = row_b <= h_ext;
      rmask[0] = (row_b >= ROW_BITS'(2)) && (row_b <= h1);
      cmask[0] = special || (col_e >= COL_BITS'(2));
      cmask[1] = 1'b1;
      cmask[2] = !special;
   end

   // Advance raster counters; a restart or the final flush word wraps to a new frame
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      col_inc = WIDTH_BITS'(col_e) + 1'b1;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (row_e == h1) begin
            row_in = '0;
            col_in = '0;
         end else if (col_inc == dims.width) begin
            row_in = row_e + 1'b1;
            col_in = '0;
         end else begin
            row_in = row_e;
            col_in = col_inc[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         b_valid_ff <= accept;
      end
   end

   // Stage B payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_emit_ff    <= special || normal;
         b_special_ff <= special;
         b_last_ff    <= last;
         b_col_ff     <= col_e;
         b_pixel_ff   <= pix;
         b_rmask_ff   <= rmask;
         b_cmask_ff   <= cmask;
      end
   end

   // Two rows per column in one RAM word: older row high, previous row low
   c2d_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data ({line_old, b_pixel_ff}),
      .rd_en   (accept),
      .rd_addr (col_e),
      .rd_data (line_rd)
   );

   assign line_old   = line_rd[PIXEL_BITS-1:0];
   assign line_older = line_rd[LINE_BITS-1:PIXEL_BITS];

   // Shift the window left by one column
   always_comb begin
      new_col[0] = line_older;
      new_col[1] = line_old;
      new_col[2] = b_pixel_ff;
      for (int a = 0; a < KTAPS; a++) begin
         win_in[a][0] = win_ff[a][1];
         win_in[a][1] = win_ff[a][2];
         win_in[a][2] = new_col[a];
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // Build the job; taps outside the image read as zero
   always_comb begin
      for (int a = 0; a < KTAPS; a++) begin
         job.taps[a][0] = (b_rmask_ff[a] && b_cmask_ff[0]) ? win_ff[a][1] : '0;
         job.taps[a][1] = (b_rmask_ff[a] && b_cmask_ff[1]) ? win_ff[a][2] : '0;
         job.taps[a][2] = (b_rmask_ff[a] && b_cmask_ff[2] && !b_special_ff) ?
                          new_col[a] : '0;
      end
      job.last = b_last_ff;
   end

   assign job_push = b_valid_ff && b_emit_ff;

   // Counters stay inside the extended frame
   assert property (@(posedge clock) disable iff (reset)
      WIDTH_BITS'(col_ff) < dims.width)
      else $error("column counter beyond row width");

   assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_BITS'(dims.height) + 1'b1)
      else $error("row counter beyond flush rows");

endmodule

### design/c2d_back.sv
// Back end: nine multiplies, adder tree, rounding and saturation, output register.
module c2d_back import c2d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  kernel_type       kernel,
   input  job_type          head,
   input  logic             head_valid,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output pixel_type        rsp_pixel,
   output logic             rsp_last
);

   prod_type [KTAPS-1:0][KTAPS-1:0] prod_ff, prod_in;
   rowsum_type [KTAPS-1:0]          rsum_ff, rsum_in;
   acc_type                         acc_ff, acc_in;
   logic                            v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic                            last1_ff, last2_ff, last3_ff;
   pixel_type                       pixel_ff, pixel_in;
   logic                            last_ff;
   logic                            advance;
   quot_type                        quot;

   // Whole pipeline moves unless the output word is stalled
   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && head_valid;

   // Products: tap [a][b] meets coefficient [2-a][2-b]
   always_comb begin
      for (int a = 0; a < KTAPS; a++) begin
         for (int b = 0; b < KTAPS; b++) begin
            prod_in[a][b] = PROD_BITS'(head.taps[a][b]) *
                            PROD_BITS'(kernel[KTAPS-1-a][KTAPS-1-b]);
         end
      end
   end

   // Row sums, then total plus half an output LSB
   always_comb begin
      for (int a = 0; a < KTAPS; a++) begin
         rsum_in[a] = ROWSUM_BITS'(prod_ff[a][0]) + ROWSUM_BITS'(prod_ff[a][1]) +
                      ROWSUM_BITS'(prod_ff[a][2]);
      end
      acc_in = ACC_BITS'(rsum_ff[0]) + ACC_BITS'(rsum_ff[1]) + ACC_BITS'(rsum_ff[2]) +
               ROUND_BIAS;
   end

   // Floor the Q24.12 sum to whole pixel units and saturate
   always_comb begin
      quot = Q_BITS'(acc_ff >>> COEF_FRAC);
      if (quot > SAT_HI) begin
         pixel_in = SAT_HI[PIXEL_BITS-1:0];
      end else if (quot < SAT_LO) begin
         pixel_in = SAT_LO[PIXEL_BITS-1:0];
      end else begin
         pixel_in = quot[PIXEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         last1_ff <= head.last;
         rsum_ff  <= rsum_in;
         last2_ff <= last1_ff;
         acc_ff   <= acc_in;
         last3_ff <= last2_ff;
         pixel_ff <= pixel_in;
         last_ff  <= last3_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_pixel  = pixel_ff;
   assign rsp_last   = last_ff;

endmodule

### design/conv2d_3x3_stream.sv
// Top level of the streaming 3x3 convolution: configuration registers and wiring.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  req_tdata = pixel_in, req_tuser = drain
//  rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata = pixel_out, rsp_tlast = frame_last
//  csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
// Sustained rate is one word per clock on both streams while rsp_ is not stalled; the
// line store is a single MAX_WIDTH-deep RAM holding two rows per column, read when
// a word is taken and written the next cycle, so one port pair covers every pixel.
// A result passes stage B, the queue (with any wait), then the product, row-sum,
// accumulator and output registers. No clearing pass after reset: taps outside the
// image are zeroed. A stall on rsp_ freezes the arithmetic pipeline; the four-entry
// queue keeps the input side running until it fills, then req_tready drops.
module conv2d_3x3_stream import c2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [PIXEL_BITS-1:0]     req_tdata,   // [15:0] pixel_in
   input  logic                      req_tuser,   // [0] drain
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [PIXEL_BITS-1:0]     rsp_tdata,   // [15:0] pixel_out
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   dims_type         dims_ff, dims_in;
   kernel_type       kernel_ff, kernel_in;
   logic             restart;
   logic             csr_write;
   logic             job_push;
   job_type          job;
   job_type          head;
   logic             pop;
   queue_status_type status;
   pixel_type        rsp_pixel;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register writes; a size write restarts the frame
   always_comb begin
      dims_in   = dims_ff;
      kernel_in = kernel_ff;
      restart   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               dims_in.width = clamp_width(csr_data[CFG_WIDTH_BITS-1:0]);
               restart       = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               dims_in.height = clamp_height(csr_data[HEIGHT_BITS-1:0]);
               restart        = 1'b1;
            end
            REG_KERNEL_TOP:    kernel_in[0] = csr_data[KROW_BITS-1:0];
            REG_KERNEL_MIDDLE: kernel_in[1] = csr_data[KROW_BITS-1:0];
            REG_KERNEL_BOTTOM: kernel_in[2] = csr_data[KROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= '{width: WIDTH_BITS'(64), height: HEIGHT_BITS'(64)};
         kernel_ff <= {KROW_BITS'(0), {COEF_BITS'(0), COEF_ONE, COEF_BITS'(0)},
                       KROW_BITS'(0)};
      end else begin
         dims_ff   <= dims_in;
         kernel_ff <= kernel_in;
      end
   end

   c2d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .dims        (dims_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_pixel   (req_tdata),
      .req_drain   (req_tuser),
      .queue_level (status.level),
      .job_push    (job_push),
      .job         (job)
   );

   c2d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   c2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .kernel     (kernel_ff),
      .head       (head),
      .head_valid (status.not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pixel  (rsp_pixel),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_pixel;

endmodule

### bench/conv2d_3x3_stream_tb.sv
// Self-checking bench for conv2d_3x3_stream: predicts every filtered pixel and checks the stream.
`timescale 1ns / 100ps

module conv2d_3x3_stream_tb;
   import c2d_pkg::*;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RAND_ITEMS    = 520;
   localparam int WIDE_ITEMS    = 40;

   // Indexes the block does not decode
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic                  drain;
   } in_word_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic                  last;
   } out_word_type;

   typedef logic [KTAPS*KTAPS-1:0][PIXEL_BITS-1:0] tapset_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [PIXEL_BITS-1:0]     req_tdata = '0;   // [15:0] pixel_in
   logic                      req_tuser = 1'b0; // [0] drain
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [PIXEL_BITS-1:0]     rsp_tdata;        // [15:0] pixel_out
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   conv2d_3x3_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #6 clock = ~clock;

   // Stimulus and expectation stores
   in_word_type  pixel_feed[$];
   out_word_type awaited_pixels[$];
   int        send_gap_pct  = 9;
   int        rsp_stall_pct = 61;
   int        mismatches = 0;
   int        pixels_taken = 0;
   int        results_checked = 0;
   int        cycle_count = 0;

   // Filter state mirrored from the block
   logic [PIXEL_BITS-1:0] prev_rows [2*MAX_WIDTH];
   tapset_type            taps;
   int                    frame_row;
   int                    frame_col;
   logic [10:0]           width_reg;
   logic [15:0]           height_reg;
   logic [KROW_BITS-1:0]  kern_row [KTAPS];

   function automatic int eff_width();
      int w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int eff_height();
      int h;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   // Shift the window left one column; the new column enters on the right
   function automatic tapset_type shift_taps(tapset_type t, logic [PIXEL_BITS-1:0] top_px,
                                             logic [PIXEL_BITS-1:0] mid_px,
                                             logic [PIXEL_BITS-1:0] new_px);
      logic [KTAPS-1:0][PIXEL_BITS-1:0] fresh;
      int a;
      fresh = {new_px, mid_px, top_px};
      for (a = 0; a < KTAPS; a++) begin
         t[a*KTAPS]   = t[a*KTAPS+1];
         t[a*KTAPS+1] = t[a*KTAPS+2];
         t[a*KTAPS+2] = fresh[a];
      end
      return t;
   endfunction

   // Convolve the window centered on (r, c); taps off the image read as zero
   function automatic logic [PIXEL_BITS-1:0] filter_at(tapset_type t, int r, int c, int w,
                                                       int h);
      longint acc;
      longint q;
      int a;
      int b;
      int rr;
      int cc;
      acc = 0;
      for (a = 0; a < KTAPS; a++) begin
         for (b = 0; b < KTAPS; b++) begin
            rr = r - 1 + a;
            cc = c - 1 + b;
            if (rr >= 0 && rr < h && cc >= 0 && cc < w)
               acc += longint'($signed(kern_row[2-a][16*(2-b) +: 16]))
                      * longint'($signed(t[a*KTAPS+b]));
         end
      end
      // round half up, then clamp to the pixel range
      acc += longint'(1) << (COEF_FRAC - 1);
      q = acc >>> COEF_FRAC;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[PIXEL_BITS-1:0];
   endfunction

   // Advance the mirrored filter by one accepted word; returns 1 when a pixel comes out
   function automatic logic predict_pixel(input logic [PIXEL_BITS-1:0] pix, input logic drain,
                                          output logic [PIXEL_BITS-1:0] opix,
                                          output logic olast);
      int w;
      int h;
      int r;
      int c;
      logic [PIXEL_BITS-1:0] v;
      logic got;
      w = eff_width();
      h = eff_height();
      r = 0;
      c = 0;
      got = 1'b0;
      opix = '0;
      olast = 1'b0;
      if (frame_col >= w || frame_row > h + 1 || (frame_row == h + 1 && frame_col != 0)) begin
         frame_row = 0;
         frame_col = 0;
      end
      v = (frame_row < h && !drain) ? pix : '0;
      // first column of a row closes the last column of the row above
      if (frame_col == 0 && frame_row >= 2) begin
         r = frame_row - 2;
         c = w - 1;
         opix = filter_at(shift_taps(taps, '0, '0, '0), r, c, w, h);
         got = 1'b1;
      end
      taps = shift_taps(taps, prev_rows[MAX_WIDTH+frame_col], prev_rows[frame_col], v);
      prev_rows[MAX_WIDTH+frame_col] = prev_rows[frame_col];
      prev_rows[frame_col] = v;
      if (frame_col >= 1 && frame_row >= 1) begin
         r = frame_row - 1;
         c = frame_col - 1;
         opix = filter_at(taps, r, c, w, h);
         got = 1'b1;
      end
      if (got) olast = (r == h - 1 && c == w - 1);
      if (frame_row == h + 1) begin
         frame_row = 0;
         frame_col = 0;
      end else begin
         frame_col++;
         if (frame_col == w) begin
            frame_col = 0;
            frame_row++;
         end
      end
      return got;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_IMAGE_WIDTH: begin
            width_reg = data[10:0];
            frame_row = 0;
            frame_col = 0;
         end
         REG_IMAGE_HEIGHT: begin
            height_reg = data[15:0];
            frame_row = 0;
            frame_col = 0;
         end
         REG_KERNEL_TOP:    kern_row[0] = data;
         REG_KERNEL_MIDDLE: kern_row[1] = data;
         REG_KERNEL_BOTTOM: kern_row[2] = data;
         default: ;
      endcase
   endfunction

   task automatic note_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [PIXEL_BITS-1:0] rand_pixel();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(2047)) - 16'd1024;
         2: return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(7)) - 16'd4;
      endcase
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1, 2: return 16'($urandom_range(4095)) - 16'd2048;
         default: return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   // Queue one frame plus its flush; keep >= 0 cuts it short after that many words
   function automatic int queue_frame(int w, int h, int keep, int noise_pct);
      int total;
      int i;
      total = w * h + w + 1;
      if (keep >= 0 && keep < total) total = keep;
      for (i = 0; i < total; i++) begin
         if (i < w * h)
            pixel_feed.push_back('{value: rand_pixel(),
                                   drain: ($urandom_range(99) < noise_pct)});
         else
            pixel_feed.push_back('{value: 16'($urandom),
                                   drain: !($urandom_range(99) < noise_pct)});
      end
      return total;
   endfunction

   // Driver: retire the word on the bus, then present the next one or idle
   always @(posedge clock) begin
      in_word_type next_word;
      logic     has_result;
      logic [PIXEL_BITS-1:0] got_pix;
      logic     got_last;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            has_result = predict_pixel(req_tdata, req_tuser, got_pix, got_last);
            if (has_result) awaited_pixels.push_back('{value: got_pix, last: got_last});
            pixels_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_feed.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_word = pixel_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_word.value;
               req_tuser  <= next_word.drain;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result word with the oldest awaited pixel
   always @(posedge clock) begin
      out_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_pixels.size() == 0) begin
               note_mismatch($sformatf("pixel_out %h arrived with none awaited", rsp_tdata));
            end else begin
               want = awaited_pixels.pop_front();
               if (rsp_tdata !== want.value)
                  note_mismatch($sformatf("result %0d pixel_out %h, want %h",
                                          results_checked, rsp_tdata, want.value));
               if (rsp_tlast !== want.last)
                  note_mismatch($sformatf("result %0d frame_last %b, want %b",
                                          results_checked, rsp_tlast, want.last));
               results_checked++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TIMEOUT after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_pixels.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(idx, data);
   endtask

   task automatic load_kernel();
      write_csr(REG_KERNEL_TOP,    {rand_coef(), rand_coef(), rand_coef()});
      write_csr(REG_KERNEL_MIDDLE, {rand_coef(), rand_coef(), rand_coef()});
      write_csr(REG_KERNEL_BOTTOM, {rand_coef(), rand_coef(), rand_coef()});
   endtask

   // Hold until the feed is empty and every result is in, then let the pipeline drain
   task automatic settle();
      do @(posedge clock);
      while (pixel_feed.size() != 0 || req_tvalid || awaited_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int i;
      int rand_items;
      int settings_used;
      int pick;
      int wv;
      int hv;
      int frames;
      logic aligned;

      // mirror the reset state
      for (i = 0; i < 2 * MAX_WIDTH; i++) prev_rows[i] = '0;
      taps = '0;
      frame_row = 0;
      frame_col = 0;
      width_reg = 11'd64;
      height_reg = 16'd64;
      kern_row[0] = '0;
      kern_row[1] = 48'h0000_1000_0000;
      kern_row[2] = '0;
      rand_items = 0;
      settings_used = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3x3 frame with a half-weight center tap to hit rounding ties
      write_csr(REG_IMAGE_WIDTH, 48'd3);
      write_csr(REG_IMAGE_HEIGHT, 48'd3);
      write_csr(REG_KERNEL_TOP, '0);
      write_csr(REG_KERNEL_MIDDLE, {16'h0000, 16'h0800, 16'h0000});
      write_csr(REG_KERNEL_BOTTOM, '0);
      settings_used++;
      pixel_feed.push_back('{value: 16'h7FFF, drain: 1'b0});
      pixel_feed.push_back('{value: 16'h8000, drain: 1'b0});
      pixel_feed.push_back('{value: 16'h0001, drain: 1'b0});
      pixel_feed.push_back('{value: 16'hFFFF, drain: 1'b0});
      pixel_feed.push_back('{value: 16'h0003, drain: 1'b0});
      pixel_feed.push_back('{value: 16'hFFFD, drain: 1'b0});
      // drain inside the image reads as zero
      pixel_feed.push_back('{value: 16'h1234, drain: 1'b1});
      pixel_feed.push_back('{value: 16'h0005, drain: 1'b0});
      pixel_feed.push_back('{value: 16'hFFFB, drain: 1'b0});
      // flush word without drain: pixel ignored
      pixel_feed.push_back('{value: 16'h7FFF, drain: 1'b0});
      for (i = 0; i < 3; i++) pixel_feed.push_back('{value: 16'hFFFF, drain: 1'b1});
      settle();

      // Directed: extreme kernel against a checkerboard saturates both ways
      write_csr(REG_SPARE_FIRST, 48'($urandom));
      write_csr(REG_KERNEL_TOP,    {16'h7FFF, 16'h8000, 16'h7FFF});
      write_csr(REG_KERNEL_MIDDLE, {16'h8000, 16'h7FFF, 16'h8000});
      write_csr(REG_KERNEL_BOTTOM, {16'h7FFF, 16'h8000, 16'h7FFF});
      settings_used++;
      for (i = 0; i < 9; i++)
         pixel_feed.push_back('{value: (i % 2 != 0) ? 16'h8000 : 16'h7FFF, drain: 1'b0});
      for (i = 0; i < 4; i++) pixel_feed.push_back('{value: '0, drain: 1'b1});
      settle();

      // Random phases: mostly whole frames, some cut short or raw noise
      aligned = 1'b1;
      while (rand_items < RAND_ITEMS) begin
         if (rand_items < RAND_ITEMS / 3) begin
            send_gap_pct = 9;
            rsp_stall_pct = 61;
         end else if (rand_items < 2 * RAND_ITEMS / 3) begin
            send_gap_pct = 61;
            rsp_stall_pct = 9;
         end else begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         if (!aligned || $urandom_range(2) == 0) begin
            case ($urandom_range(5))
               0: wv = $urandom_range(0, 2);
               1: wv = $urandom_range(11, 24);
               default: wv = $urandom_range(3, 10);
            endcase
            hv = ($urandom_range(4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            pick = $urandom_range(2);
            if (pick != 1) write_csr(REG_IMAGE_WIDTH, {37'({$urandom, $urandom}), 11'(wv)});
            if (pick != 0) write_csr(REG_IMAGE_HEIGHT, {32'($urandom), 16'(hv)});
            aligned = 1'b1;
         end
         if ($urandom_range(1) == 0) load_kernel();
         if ($urandom_range(5) == 0)
            write_csr(CSR_INDEX_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      48'({$urandom, $urandom}));
         settings_used++;
         pick = $urandom_range(9);
         if (pick < 7) begin
            frames = $urandom_range(1, 2);
            for (i = 0; i < frames; i++)
               rand_items += queue_frame(eff_width(), eff_height(), -1, $urandom_range(0, 6));
         end else if (pick < 9) begin
            rand_items += queue_frame(eff_width(), eff_height(),
                                      $urandom_range(1, eff_width() * eff_height()), 5);
            aligned = 1'b0;
         end else begin
            frames = $urandom_range(10, 40);
            for (i = 0; i < frames; i++)
               pixel_feed.push_back('{value: 16'($urandom), drain: 1'($urandom)});
            rand_items += frames;
            aligned = 1'b0;
         end
         settle();
      end

      // Tallest frame: only its first rows
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      write_csr(REG_IMAGE_WIDTH, 48'($urandom_range(3, 6)));
      write_csr(REG_IMAGE_HEIGHT, 48'hFFFF);
      load_kernel();
      settings_used++;
      void'(queue_frame(eff_width(), eff_height(), 60, 3));
      settle();

      // Widest frame: width written at or above the cap, only the start of its first row
      write_csr(REG_IMAGE_WIDTH, 48'($urandom_range(MAX_WIDTH, 2047)));
      write_csr(REG_IMAGE_HEIGHT, 48'($urandom_range(0, 3)));
      load_kernel();
      settings_used++;
      void'(queue_frame(eff_width(), eff_height(), WIDE_ITEMS, 2));
      settle();

      $display("%0d pixel words sent, %0d filtered pixels checked over %0d register settings",
               pixels_taken, results_checked, settings_used);
      $display("covered widths 3..24 plus a capped-width start, heights 3..65535,");
      $display("rounding ties, saturation, drain and flush noise, cut-short frames");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/c2d_pkg.sv
design/c2d_ram.sv
design/c2d_queue.sv
design/c2d_front.sv
design/c2d_back.sv
design/conv2d_3x3_stream.sv
bench/conv2d_3x3_stream_tb.sv
